// ----- hw/rtl/lwmm_pkg.sv -----
// Shared types, register map and channel compare helpers for the line window
// min/max filter. No dependencies.
package lwmm_pkg;

    localparam int MAX_RADIUS_DEF = 15;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam int RADIUS_W       = 4;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_RADIUS = 1'b1;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic                mode;
        logic [RADIUS_W-1:0] radius;
    } t_cfg;

    function automatic t_pixel pix_min(input t_pixel a, input t_pixel b);
        t_pixel res;
        res.alpha = (a.alpha < b.alpha) ? a.alpha : b.alpha;
        res.red   = (a.red   < b.red)   ? a.red   : b.red;
        res.green = (a.green < b.green) ? a.green : b.green;
        res.blue  = (a.blue  < b.blue)  ? a.blue  : b.blue;
        return res;
    endfunction

    function automatic t_pixel pix_max(input t_pixel a, input t_pixel b);
        t_pixel res;
        res.alpha = (a.alpha > b.alpha) ? a.alpha : b.alpha;
        res.red   = (a.red   > b.red)   ? a.red   : b.red;
        res.green = (a.green > b.green) ? a.green : b.green;
        res.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
        return res;
    endfunction

endpackage

// ----- hw/rtl/lwmm_regs.sv -----
// APB-style configuration registers (mode, radius) of the min/max filter.
// Depends on lwmm_pkg.
module lwmm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lwmm_pkg::ADDR_W-1:0]   paddr,
    input  logic [lwmm_pkg::DATA_W-1:0]   pwdata,
    output logic [lwmm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output lwmm_pkg::t_cfg                o_cfg
);

    lwmm_pkg::t_cfg r_cfg;
    lwmm_pkg::t_cfg n_cfg;
    logic           w_wr;
    logic           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                lwmm_pkg::REG_MODE:   n_cfg.mode   = pwdata[0];
                lwmm_pkg::REG_RADIUS: n_cfg.radius = pwdata[lwmm_pkg::RADIUS_W-1:0];
                default:              n_cfg        = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= lwmm_pkg::MODE_ERODE;
            r_cfg.radius <= lwmm_pkg::RADIUS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            lwmm_pkg::REG_MODE:   prdata = lwmm_pkg::DATA_W'(r_cfg.mode);
            lwmm_pkg::REG_RADIUS: prdata = lwmm_pkg::DATA_W'(r_cfg.radius);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/lwmm_cell.sv -----
// One window cell: holds the channel min and max over the newest pixels up
// to its age, fed from the neighbor one age younger. Depends on lwmm_pkg.
module lwmm_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  lwmm_pkg::t_pixel i_new,
    input  lwmm_pkg::t_pixel i_prev_min,
    input  lwmm_pkg::t_pixel i_prev_max,
    output lwmm_pkg::t_pixel o_min,
    output lwmm_pkg::t_pixel o_max
);

    lwmm_pkg::t_pixel r_min;
    lwmm_pkg::t_pixel r_max;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_min <= lwmm_pkg::pix_min(i_new, i_prev_min);
            r_max <= lwmm_pkg::pix_max(i_new, i_prev_max);
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

// ----- hw/rtl/lwmm_chain.sv -----
// Row of window cells: cell j holds min/max over pixel ages 0..j of the
// stream. Output picks one cell by age. Depends on lwmm_pkg, lwmm_cell.
module lwmm_chain #(
    parameter int DEPTH = 2 * lwmm_pkg::MAX_RADIUS_DEF + 1,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  lwmm_pkg::t_pixel i_pix,
    input  logic [IW-1:0]    i_sel,
    input  logic             i_mode,
    output lwmm_pkg::t_pixel o_pix
);

    lwmm_pkg::t_pixel w_min [DEPTH];
    lwmm_pkg::t_pixel w_max [DEPTH];

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++) begin : g_cell
            if (j == 0) begin : g_head
                // newest age: combine the pixel with itself
                lwmm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_en       (i_en),
                    .i_new      (i_pix),
                    .i_prev_min (i_pix),
                    .i_prev_max (i_pix),
                    .o_min      (w_min[j]),
                    .o_max      (w_max[j])
                );
            end else begin : g_body
                lwmm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_en       (i_en),
                    .i_new      (i_pix),
                    .i_prev_min (w_min[j-1]),
                    .i_prev_max (w_max[j-1]),
                    .o_min      (w_min[j]),
                    .o_max      (w_max[j])
                );
            end
        end
    endgenerate

    assign o_pix = (i_mode == lwmm_pkg::MODE_DILATE) ? w_max[i_sel] : w_min[i_sel];

endmodule

// ----- hw/rtl/line_window_min_max_filter_core.sv -----
// Line window min/max filter: per-channel erode/dilate over +-radius pixels.
// o_out_valid is registered: an accepted pixel sets r_busy, and the result load then sets r_ovalid.
// Throughput: one pixel per cycle while results drain (i_out_ready high); a line end flushes
// min(radius, position)+1 results, one per cycle when not stalled, and input waits until the last.
// Reset: control, position count and output valid clear; mode 0, radius 1.
// Window cells are not reset; only the current line's cells are ever read.
module line_window_min_max_filter_core #(
    parameter int MAX_RADIUS = lwmm_pkg::MAX_RADIUS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lwmm_pkg::ADDR_W-1:0] paddr,
    input  logic [lwmm_pkg::DATA_W-1:0] pwdata,
    output logic [lwmm_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_in_alpha,
    input  logic [7:0]                  i_in_red,
    input  logic [7:0]                  i_in_green,
    input  logic [7:0]                  i_in_blue,
    input  logic                        i_line_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_out_alpha,
    output logic [7:0]                  o_out_red,
    output logic [7:0]                  o_out_green,
    output logic [7:0]                  o_out_blue,
    output logic                        o_line_done
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);

    lwmm_pkg::t_cfg   w_cfg;
    lwmm_pkg::t_pixel w_in_pix;
    lwmm_pkg::t_pixel w_sel_pix;
    lwmm_pkg::t_pixel r_out;

    logic           r_busy,   n_busy;
    logic           r_end,    n_end;
    logic [IW-1:0]  r_k,      n_k;
    logic [IW-1:0]  r_rad,    n_rad;
    logic [PW-1:0]  r_epos,   n_epos;
    logic [PW-1:0]  r_pos,    n_pos;
    logic           r_ovalid, n_ovalid;
    logic           r_done;

    logic           w_acc;
    logic           w_load;
    logic           w_last;
    logic [IW-1:0]  w_reff;
    logic [IW-1:0]  w_sum;
    logic [IW-1:0]  w_sel;

    lwmm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_in_pix = '{alpha: i_in_alpha, red: i_in_red,
                        green: i_in_green, blue: i_in_blue};

    // clamp radius to what the cell row covers
    assign w_reff = (32'(w_cfg.radius) > MAX_RADIUS) ? IW'(MAX_RADIUS)
                                                     : IW'(w_cfg.radius);

    assign w_load     = r_busy & (~r_ovalid | i_out_ready);
    assign w_last     = ~r_end | (r_k == '0);
    assign o_in_ready = ~r_busy | (w_load & w_last);
    assign w_acc      = i_in_valid & o_in_ready;

    // window reaches back k+r ages, clipped to the line start
    assign w_sum = r_k + r_rad;
    assign w_sel = (PW'(w_sum) > r_epos) ? IW'(r_epos) : w_sum;

    lwmm_chain #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_chain (
        .i_clk  (i_clk),
        .i_en   (w_acc),
        .i_pix  (w_in_pix),
        .i_sel  (w_sel),
        .i_mode (w_cfg.mode),
        .o_pix  (w_sel_pix)
    );

    always_comb begin
        n_busy = r_busy;
        n_k    = r_k;
        n_end  = r_end;
        n_rad  = r_rad;
        n_epos = r_epos;
        n_pos  = r_pos;
        if (w_load) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_k = r_k - IW'(1);
            end
        end
        if (w_acc) begin
            n_end  = i_line_end;
            n_rad  = w_reff;
            n_epos = r_pos;
            if (i_line_end) begin
                n_busy = 1'b1;
                n_k    = (PW'(w_reff) < r_pos) ? w_reff : IW'(r_pos);
                n_pos  = '0;
            end else begin
                n_busy = (r_pos >= PW'(w_reff));
                n_k    = w_reff;
                n_pos  = (r_pos < PW'(DEPTH)) ? r_pos + PW'(1) : r_pos;
            end
        end
        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_end  <= n_end;
        r_rad  <= n_rad;
        r_epos <= n_epos;
        if (w_load) begin
            r_out  <= w_sel_pix;
            r_done <= r_end & (r_k == '0);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_alpha = r_out.alpha;
    assign o_out_red   = r_out.red;
    assign o_out_green = r_out.green;
    assign o_out_blue  = r_out.blue;
    assign o_line_done = r_done;

endmodule
